FILE: sv/ftc_pkg.sv
// ----------------------------------------------------------------------------
// ftc_pkg
// shared types, constants and saturating helpers for the throttle curve unit
// ----------------------------------------------------------------------------
package ftc_pkg;

	localparam int FRAC_BITS = 15;
	localparam int INT_FRAC  = 24;
	localparam int SHIFT     = INT_FRAC - FRAC_BITS;
	localparam int QW        = 32;
	localparam int PROD_W    = 2 * QW;
	localparam int NUM_W     = PROD_W + 1;
	localparam int KNOTS     = 5;
	localparam int NREGS     = 7;
	localparam int CFG_AW    = 5;
	localparam int IN_W      = 16;

	// divider: prep stage, one stage per quotient bit, output stage
	localparam int DIV_LAT   = QW + 2;
	localparam int LVL_LAT   = DIV_LAT + 3;
	localparam int BLEND_LAT = 4;
	localparam int PIPE_LAT  = (KNOTS - 1) * LVL_LAT + BLEND_LAT;

	typedef logic signed [QW-1:0]     q824_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [NUM_W-1:0]  num_t;

	localparam q824_t Q_MAX = q824_t'(32'h7FFF_FFFF);
	localparam q824_t Q_MIN = q824_t'(32'h8000_0000);
	localparam q824_t Q_ONE = q824_t'(64'd1 << INT_FRAC);
	localparam logic [IN_W-1:0] OUT_ONE = IN_W'(64'd1 << FRAC_BITS);

	typedef enum logic [2:0] {
		REG_X1    = 3'd0,
		REG_X2    = 3'd1,
		REG_X3    = 3'd2,
		REG_Y1    = 3'd3,
		REG_Y2    = 3'd4,
		REG_Y3    = 3'd5,
		REG_BLEND = 3'd6
	} reg_idx_t;

	localparam logic [IN_W-1:0] RST_X1    = 16'd8192;
	localparam logic [IN_W-1:0] RST_X2    = 16'd16384;
	localparam logic [IN_W-1:0] RST_X3    = 16'd24576;
	localparam logic [IN_W-1:0] RST_Y1    = 16'd8192;
	localparam logic [IN_W-1:0] RST_Y2    = 16'd16384;
	localparam logic [IN_W-1:0] RST_Y3    = 16'd24576;
	localparam logic [IN_W-1:0] RST_BLEND = 16'd0;

	// raw Q1.FRAC_BITS to Q8.24, saturating
	function automatic q824_t to_q824(logic [IN_W-1:0] raw);
		logic [PROD_W-1:0] w;
		w = PROD_W'(raw) << SHIFT;
		if (w > PROD_W'(32'h7FFF_FFFF)) begin
			return Q_MAX;
		end
		return q824_t'(w[QW-1:0]);
	endfunction

	function automatic q824_t sat33(logic signed [QW:0] v);
		if (v[QW] != v[QW-1]) begin
			return v[QW] ? Q_MIN : Q_MAX;
		end
		return q824_t'(v[QW-1:0]);
	endfunction

	function automatic q824_t sat64(prod_t v);
		if (!((&v[PROD_W-1:QW-1]) || !(|v[PROD_W-1:QW-1]))) begin
			return v[PROD_W-1] ? Q_MIN : Q_MAX;
		end
		return q824_t'(v[QW-1:0]);
	endfunction

endpackage

FILE: sv/ftc_div.sv
// ----------------------------------------------------------------------------
// ftc_div
// pipelined signed divider, one quotient bit per stage, saturating quotient
// ----------------------------------------------------------------------------
module ftc_div #(
	parameter int LANES = 1,
	parameter int TAG_W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  ftc_pkg::num_t       in_num [LANES],
	input  ftc_pkg::q824_t      in_den [LANES],
	input  logic [TAG_W-1:0]    in_tag,
	output logic                out_valid,
	output ftc_pkg::q824_t      out_quot [LANES],
	output logic [TAG_W-1:0]    out_tag
);

	localparam int W = ftc_pkg::QW;

	// stage 0 is prep, stages 1..W are quotient bits
	logic             vld_s [W+1];
	logic [TAG_W-1:0] tag_s [W+1];
	logic [W-1:0]     rem_s [W+1][LANES];
	logic [W-1:0]     lo_s  [W+1][LANES];
	logic [W-1:0]     q_s   [W+1][LANES];
	logic [W-1:0]     dd_s  [W+1][LANES];
	logic             neg_s [W+1][LANES];
	logic             ovf_s [W+1][LANES];

	logic [ftc_pkg::PROD_W-1:0] n_abs [LANES];
	logic [W-1:0]               d_abs [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			n_abs[l] = in_num[l][ftc_pkg::NUM_W-1] ? ftc_pkg::PROD_W'(-in_num[l])
				: ftc_pkg::PROD_W'(in_num[l]);
			d_abs[l] = in_den[l][W-1] ? W'(-in_den[l]) : W'(in_den[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tag_s[0] <= in_tag;
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] <= n_abs[l][ftc_pkg::PROD_W-1:W];
			lo_s[0][l]  <= n_abs[l][W-1:0];
			q_s[0][l]   <= '0;
			dd_s[0][l]  <= d_abs[l];
			neg_s[0][l] <= in_num[l][ftc_pkg::NUM_W-1] ^ in_den[l][W-1];
			ovf_s[0][l] <= n_abs[l][ftc_pkg::PROD_W-1:W] >= d_abs[l];
		end
	end

	for (genvar s = 1; s <= W; s++) begin : g_step
		logic [W:0] cand [LANES];
		logic       take [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				cand[l] = {rem_s[s-1][l], lo_s[s-1][l][W-1]};
				take[l] = cand[l] >= {1'b0, dd_s[s-1][l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s] <= 1'b0;
			end else begin
				vld_s[s] <= vld_s[s-1];
			end
		end

		always_ff @(posedge clk) begin
			tag_s[s] <= tag_s[s-1];
			for (int l = 0; l < LANES; l++) begin
				rem_s[s][l] <= take[l] ? W'(cand[l] - {1'b0, dd_s[s-1][l]}) : W'(cand[l]);
				lo_s[s][l]  <= {lo_s[s-1][l][W-2:0], 1'b0};
				q_s[s][l]   <= {q_s[s-1][l][W-2:0], take[l]};
				dd_s[s][l]  <= dd_s[s-1][l];
				neg_s[s][l] <= neg_s[s-1][l];
				ovf_s[s][l] <= ovf_s[s-1][l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[W];
		end
	end

	// sign and saturation to the 32-bit range
	always_ff @(posedge clk) begin
		out_tag <= tag_s[W];
		for (int l = 0; l < LANES; l++) begin
			if (neg_s[W][l]) begin
				if (ovf_s[W][l] || (q_s[W][l] > 32'h8000_0000)) begin
					out_quot[l] <= ftc_pkg::Q_MIN;
				end else begin
					out_quot[l] <= ftc_pkg::q824_t'(-q_s[W][l]);
				end
			end else begin
				if (ovf_s[W][l] || q_s[W][l][W-1]) begin
					out_quot[l] <= ftc_pkg::Q_MAX;
				end else begin
					out_quot[l] <= ftc_pkg::q824_t'(q_s[W][l]);
				end
			end
		end
	end

endmodule

FILE: sv/ftc_linear.sv
// ----------------------------------------------------------------------------
// ftc_linear
// piecewise-linear value through the five knots
// ----------------------------------------------------------------------------
module ftc_linear (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  ftc_pkg::q824_t t,
	input  ftc_pkg::q824_t knot_x [ftc_pkg::KNOTS],
	input  ftc_pkg::q824_t knot_y [ftc_pkg::KNOTS],
	output ftc_pkg::q824_t lin
);

	ftc_pkg::q824_t dy, dt, dx, base;
	logic           vld_s1, vld_s2;
	ftc_pkg::q824_t dy_s1, dt_s1, dx_s1, base_s1;
	ftc_pkg::prod_t prod_s2;
	ftc_pkg::q824_t dx_s2, base_s2;
	ftc_pkg::num_t  div_num [1];
	ftc_pkg::q824_t div_den [1];
	ftc_pkg::q824_t div_q   [1];
	logic           div_vld;
	logic [ftc_pkg::QW-1:0] div_tag;
	ftc_pkg::q824_t lin_s3;

	// segment select, all differences of non-negative values fit
	always_comb begin
		if (t < knot_x[1]) begin
			dy = knot_y[1];  dt = t;  dx = knot_x[1];  base = '0;
		end else if (t > knot_x[3]) begin
			dy   = knot_y[4] - knot_y[3];
			dt   = t - knot_x[3];
			dx   = knot_x[4] - knot_x[3];
			base = knot_y[3];
		end else if (t > knot_x[2]) begin
			dy   = knot_y[3] - knot_y[2];
			dt   = t - knot_x[2];
			dx   = knot_x[3] - knot_x[2];
			base = knot_y[2];
		end else if (t > knot_x[1]) begin
			dy   = knot_y[2] - knot_y[1];
			dt   = t - knot_x[1];
			dx   = knot_x[2] - knot_x[1];
			base = knot_y[1];
		end else begin
			// throttle on the first knot
			dy = '0;  dt = '0;  dx = ftc_pkg::q824_t'(1);  base = knot_y[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dy_s1   <= dy;
		dt_s1   <= dt;
		dx_s1   <= dx;
		base_s1 <= base;
		prod_s2 <= ftc_pkg::prod_t'(dy_s1) * ftc_pkg::prod_t'(dt_s1);
		dx_s2   <= dx_s1;
		base_s2 <= base_s1;
	end

	assign div_num[0] = ftc_pkg::num_t'(prod_s2);
	assign div_den[0] = dx_s2;

	ftc_div #(.LANES(1), .TAG_W(ftc_pkg::QW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_num    (div_num),
		.in_den    (div_den),
		.in_tag    (base_s2),
		.out_valid (div_vld),
		.out_quot  (div_q),
		.out_tag   (div_tag)
	);

	always_ff @(posedge clk) begin
		if (div_vld) begin
			lin_s3 <= ftc_pkg::sat33({div_q[0][ftc_pkg::QW-1], div_q[0]}
				+ {div_tag[ftc_pkg::QW-1], div_tag});
		end
	end

	assign lin = lin_s3;

endmodule

FILE: sv/ftc_level.sv
// ----------------------------------------------------------------------------
// ftc_level
// one column of the Neville scheme, one lane per updated entry
// ----------------------------------------------------------------------------
module ftc_level #(
	parameter int LVL   = 1,
	parameter int TAG_W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [TAG_W-1:0] in_tag,
	input  ftc_pkg::q824_t f_in   [ftc_pkg::KNOTS-LVL+1],
	input  ftc_pkg::q824_t knot_x [ftc_pkg::KNOTS],
	output logic           out_valid,
	output logic [TAG_W-1:0] out_tag,
	output ftc_pkg::q824_t f_out  [ftc_pkg::KNOTS-LVL]
);

	localparam int NL = ftc_pkg::KNOTS - LVL;

	ftc_pkg::q824_t t;
	logic           vld_s1, vld_s2, vld_s3;
	logic [TAG_W-1:0] tag_s1, tag_s2, tag_s3;
	ftc_pkg::q824_t a_s1 [NL];
	ftc_pkg::q824_t b_s1 [NL];
	ftc_pkg::q824_t den_s1 [NL];
	ftc_pkg::q824_t f_s1 [NL+1];
	ftc_pkg::prod_t p1_s2 [NL];
	ftc_pkg::prod_t p2_s2 [NL];
	ftc_pkg::q824_t den_s2 [NL];
	ftc_pkg::num_t  num_s3 [NL];
	ftc_pkg::q824_t den_s3 [NL];

	assign t = ftc_pkg::q824_t'(in_tag[ftc_pkg::QW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// lane k updates entry LVL+k from entries LVL+k and LVL+k-1
	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		tag_s2 <= tag_s1;
		tag_s3 <= tag_s2;
		for (int k = 0; k <= NL; k++) begin
			f_s1[k] <= f_in[k];
		end
		for (int k = 0; k < NL; k++) begin
			a_s1[k]   <= t - knot_x[k];
			b_s1[k]   <= t - knot_x[LVL+k];
			den_s1[k] <= knot_x[LVL+k] - knot_x[k];
			p1_s2[k]  <= ftc_pkg::prod_t'(a_s1[k]) * ftc_pkg::prod_t'(f_s1[k+1]);
			p2_s2[k]  <= ftc_pkg::prod_t'(b_s1[k]) * ftc_pkg::prod_t'(f_s1[k]);
			den_s2[k] <= den_s1[k];
			num_s3[k] <= ftc_pkg::num_t'(p1_s2[k]) - ftc_pkg::num_t'(p2_s2[k]);
			den_s3[k] <= den_s2[k];
		end
	end

	ftc_div #(.LANES(NL), .TAG_W(TAG_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_num    (num_s3),
		.in_den    (den_s3),
		.in_tag    (tag_s3),
		.out_valid (out_valid),
		.out_quot  (f_out),
		.out_tag   (out_tag)
	);

endmodule

FILE: sv/ftc_blend.sv
// ----------------------------------------------------------------------------
// ftc_blend
// pulls the polynomial toward the linear value, clamps and forms the result
// ----------------------------------------------------------------------------
module ftc_blend (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  ftc_pkg::q824_t              poly,
	input  ftc_pkg::q824_t              lin,
	input  ftc_pkg::q824_t              blend,
	input  logic                        err,
	output logic                        done,
	output logic [ftc_pkg::IN_W-1:0]    curve_out,
	output logic                        spacing_error
);

	localparam int W = ftc_pkg::QW;
	localparam ftc_pkg::prod_t RND = ftc_pkg::prod_t'((64'd1 << ftc_pkg::INT_FRAC) - 64'd1);

	logic           vld_s1, vld_s2, vld_s3, done_s4;
	ftc_pkg::q824_t diff_s1, poly_s1, poly_s2, poly_s3, q_s3;
	ftc_pkg::prod_t prod_s2, adj;
	ftc_pkg::q824_t mix, clamped;
	logic [ftc_pkg::IN_W-1:0] curve_s4;
	logic           err_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			done_s4 <= 1'b0;
		end else begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			done_s4 <= vld_s3;
		end
	end

	// product scaled by 2^-24 with truncation toward zero
	assign adj = prod_s2 + (prod_s2[ftc_pkg::PROD_W-1] ? RND : '0);

	always_comb begin
		mix = ftc_pkg::sat33({poly_s3[W-1], poly_s3} - {q_s3[W-1], q_s3});
		if (mix[W-1]) begin
			clamped = '0;
		end else if (mix > ftc_pkg::Q_ONE) begin
			clamped = ftc_pkg::Q_ONE;
		end else begin
			clamped = mix;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= ftc_pkg::sat33({poly[W-1], poly} - {lin[W-1], lin});
		poly_s1 <= poly;
		prod_s2 <= ftc_pkg::prod_t'(diff_s1) * ftc_pkg::prod_t'(blend);
		poly_s2 <= poly_s1;
		q_s3    <= ftc_pkg::sat64(adj >>> ftc_pkg::INT_FRAC);
		poly_s3 <= poly_s2;
		if (vld_s3) begin
			curve_s4 <= err ? '0 : ftc_pkg::IN_W'(clamped >>> ftc_pkg::SHIFT);
			err_s4   <= err;
		end
	end

	assign done          = done_s4;
	assign curve_out     = curve_s4;
	assign spacing_error = err_s4;

endmodule

FILE: sv/five_point_throttle_curve_unit.sv
// ----------------------------------------------------------------------------
// five_point_throttle_curve_unit
// throttle curve through five knots, polynomial blended with linear value
// ----------------------------------------------------------------------------
// a throttle item is taken on every clock edge where start is high; busy is
// always low, so one item per cycle is sustained. each item gives exactly one
// result, shown on curve_out and spacing_error for the single cycle in which
// done is high, after the item has passed four Neville columns of 37 stages
// each, most of them divider stages, and 4 blend stages. results come out in
// input order and cannot be stalled, so the receiver must take each one in its
// done cycle. knot and blend registers are written over the apb port and must
// only change while no item is in flight
// ----------------------------------------------------------------------------
module five_point_throttle_curve_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          start,
	output logic                          busy,
	input  logic [ftc_pkg::IN_W-1:0]      throttle_in,
	output logic                          done,
	output logic [ftc_pkg::IN_W-1:0]      curve_out,
	output logic                          spacing_error,
	// apb configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ftc_pkg::CFG_AW-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	// knot and blend registers
	logic [ftc_pkg::IN_W-1:0] x1_q, x2_q, x3_q, y1_q, y2_q, y3_q, blend_q;
	ftc_pkg::reg_idx_t        reg_idx;
	logic                     wr_en;

	// knots in q8.24, fixed end knots at 0 and 1.0
	ftc_pkg::q824_t knot_x [ftc_pkg::KNOTS];
	ftc_pkg::q824_t knot_y [ftc_pkg::KNOTS];
	ftc_pkg::q824_t blend_v;
	ftc_pkg::q824_t t_in;
	logic           knots_clash;

	// column outputs
	logic                        l1_vld, l2_vld, l3_vld, l4_vld;
	logic [ftc_pkg::QW-1:0]      l1_tag;
	logic [2*ftc_pkg::QW-1:0]    l2_tag, l3_tag, l4_tag;
	ftc_pkg::q824_t              l1_f [4];
	ftc_pkg::q824_t              l2_f [3];
	ftc_pkg::q824_t              l3_f [2];
	ftc_pkg::q824_t              l4_f [1];
	ftc_pkg::q824_t              lin;

	// fully pipelined, never holds off an item
	assign busy   = 1'b0;
	assign pready = 1'b1;

	assign reg_idx = ftc_pkg::reg_idx_t'(paddr[ftc_pkg::CFG_AW-1:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q    <= ftc_pkg::RST_X1;
			x2_q    <= ftc_pkg::RST_X2;
			x3_q    <= ftc_pkg::RST_X3;
			y1_q    <= ftc_pkg::RST_Y1;
			y2_q    <= ftc_pkg::RST_Y2;
			y3_q    <= ftc_pkg::RST_Y3;
			blend_q <= ftc_pkg::RST_BLEND;
		end else if (wr_en) begin
			case (reg_idx)
				ftc_pkg::REG_X1:    x1_q    <= pwdata[ftc_pkg::IN_W-1:0];
				ftc_pkg::REG_X2:    x2_q    <= pwdata[ftc_pkg::IN_W-1:0];
				ftc_pkg::REG_X3:    x3_q    <= pwdata[ftc_pkg::IN_W-1:0];
				ftc_pkg::REG_Y1:    y1_q    <= pwdata[ftc_pkg::IN_W-1:0];
				ftc_pkg::REG_Y2:    y2_q    <= pwdata[ftc_pkg::IN_W-1:0];
				ftc_pkg::REG_Y3:    y3_q    <= pwdata[ftc_pkg::IN_W-1:0];
				ftc_pkg::REG_BLEND: blend_q <= pwdata[ftc_pkg::IN_W-1:0];
				default: ;   // address past the register list, write dropped
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			ftc_pkg::REG_X1:    prdata = 32'(x1_q);
			ftc_pkg::REG_X2:    prdata = 32'(x2_q);
			ftc_pkg::REG_X3:    prdata = 32'(x3_q);
			ftc_pkg::REG_Y1:    prdata = 32'(y1_q);
			ftc_pkg::REG_Y2:    prdata = 32'(y2_q);
			ftc_pkg::REG_Y3:    prdata = 32'(y3_q);
			ftc_pkg::REG_BLEND: prdata = 32'(blend_q);
			default:            prdata = '0;
		endcase
	end

	// the user must keep the knots static while items are in flight; the block does
	// not enforce it, and every stage reads them straight from the registers
	assign knot_x[0] = '0;
	assign knot_x[1] = ftc_pkg::to_q824(x1_q);
	assign knot_x[2] = ftc_pkg::to_q824(x2_q);
	assign knot_x[3] = ftc_pkg::to_q824(x3_q);
	assign knot_x[4] = ftc_pkg::Q_ONE;
	assign knot_y[0] = '0;
	assign knot_y[1] = ftc_pkg::to_q824(y1_q);
	assign knot_y[2] = ftc_pkg::to_q824(y2_q);
	assign knot_y[3] = ftc_pkg::to_q824(y3_q);
	assign knot_y[4] = ftc_pkg::Q_ONE;
	assign blend_v   = ftc_pkg::to_q824(blend_q);
	assign t_in      = ftc_pkg::to_q824(throttle_in);

	// any two knot positions equal
	always_comb begin
		knots_clash = 1'b0;
		for (int i = 1; i < ftc_pkg::KNOTS; i++) begin
			for (int j = 0; j < i; j++) begin
				if (knot_x[i] == knot_x[j]) begin
					knots_clash = 1'b1;
				end
			end
		end
	end

	// first Neville column, linear value runs alongside with equal latency
	ftc_level #(.LVL(1), .TAG_W(ftc_pkg::QW)) u_lvl1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_tag    (t_in),
		.f_in      (knot_y),
		.knot_x    (knot_x),
		.out_valid (l1_vld),
		.out_tag   (l1_tag),
		.f_out     (l1_f)
	);

	ftc_linear u_lin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.t        (t_in),
		.knot_x   (knot_x),
		.knot_y   (knot_y),
		.lin      (lin)
	);

	// remaining columns carry {linear value, throttle} as tag
	ftc_level #(.LVL(2), .TAG_W(2*ftc_pkg::QW)) u_lvl2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (l1_vld),
		.in_tag    ({lin, l1_tag}),
		.f_in      (l1_f),
		.knot_x    (knot_x),
		.out_valid (l2_vld),
		.out_tag   (l2_tag),
		.f_out     (l2_f)
	);

	ftc_level #(.LVL(3), .TAG_W(2*ftc_pkg::QW)) u_lvl3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (l2_vld),
		.in_tag    (l2_tag),
		.f_in      (l2_f),
		.knot_x    (knot_x),
		.out_valid (l3_vld),
		.out_tag   (l3_tag),
		.f_out     (l3_f)
	);

	ftc_level #(.LVL(4), .TAG_W(2*ftc_pkg::QW)) u_lvl4 (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (l3_vld),
		.in_tag    (l3_tag),
		.f_in      (l3_f),
		.knot_x    (knot_x),
		.out_valid (l4_vld),
		.out_tag   (l4_tag),
		.f_out     (l4_f)
	);

	// blend, clamp and output register
	ftc_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (l4_vld),
		.poly          (l4_f[0]),
		.lin           (ftc_pkg::q824_t'(l4_tag[2*ftc_pkg::QW-1:ftc_pkg::QW])),
		.blend         (blend_v),
		.err           (knots_clash),
		.done          (done),
		.curve_out     (curve_out),
		.spacing_error (spacing_error)
	);

endmodule

FILE: sv/ftc_checker.sv
// ----------------------------------------------------------------------------
// ftc_checker
// port-level checks for the throttle curve unit
// ----------------------------------------------------------------------------
module ftc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [ftc_pkg::IN_W-1:0]   throttle_in,
	input logic                       done,
	input logic [ftc_pkg::IN_W-1:0]   curve_out,
	input logic                       spacing_error,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [ftc_pkg::CFG_AW-1:0] paddr,
	input logic [31:0]                pwdata,
	input logic [31:0]                prdata,
	input logic                       pready
);

	// every result traces back to an item taken a fixed latency earlier
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, ftc_pkg::PIPE_LAT))
		else $error("result without a matching item");

	// result never above 1.0
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (curve_out <= ftc_pkg::OUT_ONE))
		else $error("curve_out above 1.0");

	// coinciding knots force a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && spacing_error) |-> (curve_out == '0))
		else $error("spacing error with nonzero curve_out");

endmodule

bind five_point_throttle_curve_unit ftc_checker u_ftc_checker (.*);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// throttle curve unit testbench
// drives throttle items through the item channel, predicts each curve value
// and spacing flag from the current knot and blend registers, and checks
// every done strobe against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// drain time covering the pipeline depth, with some margin
	localparam int DRAIN_CYCLES = 170;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [ftc_pkg::IN_W-1:0] curve;
		logic                     err;
	} curve_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [ftc_pkg::IN_W-1:0]   throttle_in;
	logic                       done;
	logic [ftc_pkg::IN_W-1:0]   curve_out;
	logic                       spacing_error;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [ftc_pkg::CFG_AW-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;

	// shadow copy of the knot and blend registers
	logic [ftc_pkg::IN_W-1:0] knot_reg [ftc_pkg::NREGS];

	curve_result_t pending_curves [$];
	int            fail_count;
	int            cycle_count;
	int            idle_pct;

	five_point_throttle_curve_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.throttle_in  (throttle_in),
		.done         (done),
		.curve_out    (curve_out),
		.spacing_error(spacing_error),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor: Q8.24 fixed point with 32-bit saturation on every step
	// ------------------------------------------------------------------------
	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// raw Q1.15 widened to Q8.24; 16 bits shifted by 9 always fits
	function automatic longint widen_q(logic [ftc_pkg::IN_W-1:0] raw);
		return longint'({48'd0, raw}) <<< (ftc_pkg::INT_FRAC - ftc_pkg::FRAC_BITS);
	endfunction

	// one linear segment: dy * dt / dx + base, truncating division
	function automatic longint segment_value(longint dy, longint dt, longint dx,
			longint base);
		return clip32(clip32((dy * dt) / dx) + base);
	endfunction

	function automatic curve_result_t predict_curve(logic [ftc_pkg::IN_W-1:0] throttle);
		longint        kx [ftc_pkg::KNOTS];
		longint        ky [ftc_pkg::KNOTS];
		longint        nev [ftc_pkg::KNOTS];
		longint        t;
		longint        blend;
		longint        lin;
		longint        poly;
		longint        mix;
		longint        unity;
		longint        a;
		longint        b;
		longint        den;
		curve_result_t r;
		unity = longint'(1) <<< ftc_pkg::INT_FRAC;
		kx[0] = 0;
		ky[0] = 0;
		kx[4] = unity;
		ky[4] = unity;
		for (int i = 1; i <= 3; i++) begin
			kx[i] = widen_q(knot_reg[i - 1]);
			ky[i] = widen_q(knot_reg[i + 2]);
		end
		blend = widen_q(knot_reg[ftc_pkg::REG_BLEND]);
		t     = widen_q(throttle);
		// any two knot positions equal: forced zero with the error flag
		for (int i = 1; i < ftc_pkg::KNOTS; i++) begin
			for (int j = 0; j < i; j++) begin
				if (kx[i] == kx[j]) begin
					r.curve = '0;
					r.err   = 1'b1;
					return r;
				end
			end
		end
		if (t < kx[1]) begin
			lin = segment_value(ky[1], t, kx[1], 0);
		end else if (t > kx[3]) begin
			lin = segment_value(clip32(ky[4] - ky[3]), clip32(t - kx[3]),
				clip32(kx[4] - kx[3]), ky[3]);
		end else if (t > kx[2]) begin
			lin = segment_value(clip32(ky[3] - ky[2]), clip32(t - kx[2]),
				clip32(kx[3] - kx[2]), ky[2]);
		end else if (t > kx[1]) begin
			lin = segment_value(clip32(ky[2] - ky[1]), clip32(t - kx[1]),
				clip32(kx[2] - kx[1]), ky[1]);
		end else begin
			lin = ky[1];
		end
		// Neville columns, updated in place from the top down
		for (int i = 0; i < ftc_pkg::KNOTS; i++) begin
			nev[i] = ky[i];
		end
		for (int j = 1; j < ftc_pkg::KNOTS; j++) begin
			for (int i = ftc_pkg::KNOTS - 1; i >= j; i--) begin
				a      = clip32(t - kx[i - j]);
				b      = clip32(t - kx[i]);
				den    = clip32(kx[i] - kx[i - j]);
				nev[i] = clip32((a * nev[i] - b * nev[i - 1]) / den);
			end
		end
		poly = nev[ftc_pkg::KNOTS - 1];
		mix  = clip32(poly - clip32((clip32(poly - lin) * blend) / unity));
		if (mix > unity) begin
			mix = unity;
		end
		if (mix < 0) begin
			mix = 0;
		end
		r.curve = ftc_pkg::IN_W'(mix >>> (ftc_pkg::INT_FRAC - ftc_pkg::FRAC_BITS));
		r.err   = 1'b0;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------------

	// one throttle item; start stays high afterwards unless a gap is drawn
	task automatic send_throttle(logic [ftc_pkg::IN_W-1:0] value);
		@(negedge clk);
		start       = 1'b1;
		throttle_in = value;
		do begin
			@(posedge clk);
		end while (busy);
		pending_curves.push_back(predict_curve(value));
		if ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
	endtask

	// stop sending and wait until the pipeline is empty
	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_curves.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// apb write: setup cycle, then access cycle
	task automatic write_knot_reg(ftc_pkg::reg_idx_t idx, logic [ftc_pkg::IN_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = ftc_pkg::CFG_AW'(4 * int'(idx));
		pwdata  = {16'd0, value};
		@(negedge clk);
		penable = 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		knot_reg[idx] = value;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic load_curve(logic [ftc_pkg::IN_W-1:0] x1, logic [ftc_pkg::IN_W-1:0] x2,
			logic [ftc_pkg::IN_W-1:0] x3, logic [ftc_pkg::IN_W-1:0] y1,
			logic [ftc_pkg::IN_W-1:0] y2, logic [ftc_pkg::IN_W-1:0] y3,
			logic [ftc_pkg::IN_W-1:0] blend);
		wait_idle();
		write_knot_reg(ftc_pkg::REG_X1, x1);
		write_knot_reg(ftc_pkg::REG_X2, x2);
		write_knot_reg(ftc_pkg::REG_X3, x3);
		write_knot_reg(ftc_pkg::REG_Y1, y1);
		write_knot_reg(ftc_pkg::REG_Y2, y2);
		write_knot_reg(ftc_pkg::REG_Y3, y3);
		write_knot_reg(ftc_pkg::REG_BLEND, blend);
	endtask

	// mostly ordered distinct knots in range, some wild or coinciding sets
	task automatic load_random_curve();
		logic [ftc_pkg::IN_W-1:0] xs [3];
		logic [ftc_pkg::IN_W-1:0] tmp;
		int                       pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			load_curve(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
		end else if (pick < 18) begin
			tmp = 16'($urandom_range(32768));
			load_curve(tmp, tmp, 16'($urandom_range(1, 32767)),
				16'($urandom_range(32768)), 16'($urandom_range(32768)),
				16'($urandom_range(32768)), 16'($urandom_range(32768)));
		end else begin
			do begin
				for (int i = 0; i < 3; i++) begin
					xs[i] = 16'($urandom_range(1, 32767));
				end
			end while (xs[0] == xs[1] || xs[1] == xs[2] || xs[0] == xs[2]);
			// ascending order of the three positions
			for (int p = 0; p < 2; p++) begin
				for (int i = 0; i < 2 - p; i++) begin
					if (xs[i] > xs[i + 1]) begin
						tmp       = xs[i];
						xs[i]     = xs[i + 1];
						xs[i + 1] = tmp;
					end
				end
			end
			load_curve(xs[0], xs[1], xs[2], 16'($urandom_range(32768)),
				16'($urandom_range(32768)), 16'($urandom_range(32768)),
				($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(32768)));
		end
	endtask

	function automatic logic [ftc_pkg::IN_W-1:0] random_throttle();
		// mostly the legal range, now and then any 16-bit value
		if ($urandom_range(9) == 0) begin
			return 16'($urandom);
		end
		return 16'($urandom_range(32768));
	endfunction

	// ------------------------------------------------------------------------
	// result checker: one result per done cycle, oldest prediction first
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		curve_result_t want;
		if (arst_n && done) begin
			if (pending_curves.size() == 0) begin
				$display("%0t: unexpected result curve_out=%0d spacing_error=%0b",
					$time, curve_out, spacing_error);
				fail_count++;
			end else begin
				want = pending_curves.pop_front();
				if (curve_out !== want.curve) begin
					$display("%0t: curve_out expected %0d actual %0d",
						$time, want.curve, curve_out);
					fail_count++;
				end
				if (spacing_error !== want.err) begin
					$display("%0t: spacing_error expected %0b actual %0b",
						$time, want.err, spacing_error);
					fail_count++;
				end
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset curve: end points, all-ones throttle, exact knot hits
	task automatic test_reset_curve();
		send_throttle(16'd0);
		send_throttle(16'd32768);
		send_throttle(16'hFFFF);
		send_throttle(ftc_pkg::RST_X1);
		send_throttle(ftc_pkg::RST_X2);
		send_throttle(ftc_pkg::RST_X3);
		send_throttle(16'd1);
		send_throttle(16'd32767);
		send_throttle(16'h5555);
		send_throttle(16'hAAAA);
	endtask

	// coinciding knots, including with the fixed end knots
	task automatic test_spacing_error();
		load_curve(16'd0, 16'd16384, 16'd24576, 16'd8192, 16'd16384, 16'd24576, 16'd0);
		send_throttle(16'd100);
		load_curve(16'd8192, 16'd16384, 16'd32768, 16'd8192, 16'd16384,
			16'd24576, 16'd0);
		send_throttle(16'd20000);
		load_curve(16'd9000, 16'd9000, 16'd24576, 16'd8192, 16'd16384, 16'd24576, 16'd0);
		send_throttle(16'd9000);
	endtask

	// unordered knots and values above 1.0
	task automatic test_unordered_knots();
		load_curve(16'd24576, 16'd8192, 16'd16384, 16'd30000, 16'd2000,
			16'd16000, 16'd16384);
		send_throttle(16'd4000);
		send_throttle(16'd12000);
		send_throttle(16'd20000);
		send_throttle(16'd30000);
		load_curve(16'hFFFF, 16'd40000, 16'd12000, 16'hFFFF, 16'hFFFF, 16'd0,
			16'hFFFF);
		send_throttle(16'd6000);
		send_throttle(16'hFFFF);
	endtask

	// blend extremes: pure linear, beyond linear
	task automatic test_blend_extremes();
		load_curve(16'd4000, 16'd20000, 16'd28000, 16'd16000, 16'd18000,
			16'd32000, 16'd32768);
		send_throttle(16'd2000);
		send_throttle(16'd12000);
		wait_idle();
		write_knot_reg(ftc_pkg::REG_BLEND, 16'hFFFF);
		send_throttle(16'd24000);
		send_throttle(16'd30000);
	endtask

	// random curves and throttle values under several pacing phases
	task automatic test_random_mapping();
		int pcts [4] = '{0, 69, 15, 0};
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = pcts[phase];
			for (int blk = 0; blk < 4; blk++) begin
				load_random_curve();
				repeat (85) send_throttle(random_throttle());
			end
		end
		// hold off until the pipeline has emptied, then resume
		wait_idle();
		repeat (40) send_throttle(random_throttle());
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		throttle_in = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		fail_count  = 0;
		cycle_count = 0;
		idle_pct    = 0;
		knot_reg[ftc_pkg::REG_X1]    = ftc_pkg::RST_X1;
		knot_reg[ftc_pkg::REG_X2]    = ftc_pkg::RST_X2;
		knot_reg[ftc_pkg::REG_X3]    = ftc_pkg::RST_X3;
		knot_reg[ftc_pkg::REG_Y1]    = ftc_pkg::RST_Y1;
		knot_reg[ftc_pkg::REG_Y2]    = ftc_pkg::RST_Y2;
		knot_reg[ftc_pkg::REG_Y3]    = ftc_pkg::RST_Y3;
		knot_reg[ftc_pkg::REG_BLEND] = ftc_pkg::RST_BLEND;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_curve();
		test_spacing_error();
		test_unordered_knots();
		test_blend_extremes();
		test_random_mapping();

		wait_idle();
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/ftc_pkg.sv
sv/ftc_div.sv
sv/ftc_linear.sv
sv/ftc_level.sv
sv/ftc_blend.sv
sv/five_point_throttle_curve_unit.sv
sv/ftc_checker.sv
sim/testbench.sv
